>>> rtl/rc5_block_cipher_macros.svh
// Assertion macros for the RC5 block cipher RTL.
// Included by modules that carry concurrent assertions; depends on nothing.
`ifndef RC5_BLOCK_CIPHER_MACROS_SVH
`define RC5_BLOCK_CIPHER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RC5_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RC5_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rc5_pkg.sv
// Shared types, constants and rotate functions for the RC5 block cipher.
// Used by the round unit and the top level; depends on nothing.
`default_nettype none

package rc5_pkg;

  localparam int WORD_W       = 32;
  localparam int ROT_W        = 5;
  localparam int CMD_W        = 2;
  localparam int KEY_IDX_W    = 5;
  localparam int ROUNDS_W     = 4;
  localparam int MAX_ROUNDS_D = 12;
  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 4'd12;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ENCRYPT = 2'd1,
    CMD_DECRYPT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WHITEN,
    ST_ROUND,
    ST_FINISH
  } st_t;

  typedef struct packed {
    logic decrypt;
    logic whiten;
  } round_ctrl_t;

  function automatic word_t rotl32(input word_t x, input logic [ROT_W-1:0] n);
    logic [2*WORD_W-1:0] d;
    d = {x, x} << n;
    return d[2*WORD_W-1:WORD_W];
  endfunction

  function automatic word_t rotr32(input word_t x, input logic [ROT_W-1:0] n);
    logic [2*WORD_W-1:0] d;
    d = {x, x} >> n;
    return d[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/rc5_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds key table words; depends on nothing.
`default_nettype none

module rc5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 13,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/rc5_round.sv
// One RC5 round, forward or inverse, or the key whitening step.
// Depends on rc5_pkg for the word type, control struct and rotate functions.
`default_nettype none

module rc5_round (
  input  wire rc5_pkg::round_ctrl_t ctrl,
  input  wire rc5_pkg::word_t       a,
  input  wire rc5_pkg::word_t       b,
  input  wire rc5_pkg::word_t       s_even,
  input  wire rc5_pkg::word_t       s_odd,
  output rc5_pkg::word_t            a_new,
  output rc5_pkg::word_t            b_new
);
  import rc5_pkg::*;

  word_t enc_a;
  word_t enc_b;
  word_t dec_a;
  word_t dec_b;

  always_comb begin
    enc_a = rotl32(a ^ b, b[ROT_W-1:0]) + s_even;
    enc_b = rotl32(b ^ enc_a, enc_a[ROT_W-1:0]) + s_odd;
    dec_b = rotr32(b - s_odd, a[ROT_W-1:0]) ^ a;
    dec_a = rotr32(a - s_even, dec_b[ROT_W-1:0]) ^ dec_b;
  end

  always_comb begin
    case ({ctrl.whiten, ctrl.decrypt})
      2'b10: begin
        a_new = a + s_even;
        b_new = b + s_odd;
      end
      2'b11: begin
        a_new = a - s_even;
        b_new = b - s_odd;
      end
      2'b01: begin
        a_new = dec_a;
        b_new = dec_b;
      end
      default: begin
        a_new = enc_a;
        b_new = enc_b;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/rc5_block_cipher.sv
// RC5-32 block cipher top level: key table storage, sequencer and output register.
// Depends on rc5_pkg, rc5_ram, rc5_round and rc5_block_cipher_macros.svh.
// Sequence: a whitening state, the round state for each of r rounds (r is the round count
// clamped to MAX_ROUNDS), then a finish state that waits until the output register is free;
// decryption does the rounds first. New blocks and key loads (one per cycle) wait for idle.
// Synchronous active-high reset clears the sequencer and sets rounds to 12, not the key table.
`default_nettype none

module rc5_block_cipher #(
  parameter int MAX_ROUNDS = rc5_pkg::MAX_ROUNDS_D
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         rounds_we,
  input  wire logic [rc5_pkg::ROUNDS_W-1:0] rounds_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [rc5_pkg::CMD_W-1:0]    cmd,
  input  wire logic [rc5_pkg::KEY_IDX_W-1:0] key_index,
  input  wire logic [rc5_pkg::WORD_W-1:0]   key_word,
  input  wire logic [rc5_pkg::WORD_W-1:0]   half_a,
  input  wire logic [rc5_pkg::WORD_W-1:0]   half_b,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [rc5_pkg::WORD_W-1:0]   out_a,
  output logic      [rc5_pkg::WORD_W-1:0]   out_b
);
  import rc5_pkg::*;

  `include "rc5_block_cipher_macros.svh"

  localparam int PAIRS     = MAX_ROUNDS + 1;
  localparam int KEY_DEPTH = 2 * MAX_ROUNDS + 2;
  localparam int CNT_W     = $clog2(MAX_ROUNDS + 1);

  st_t state;
  st_t state_next;

  logic [ROUNDS_W-1:0] rounds;
  logic [CNT_W-1:0]    eff_rounds;
  logic [CNT_W-1:0]    last;
  logic [CNT_W-1:0]    cnt;
  logic                dec;
  word_t               a_reg;
  word_t               b_reg;

  logic                accept;
  logic                blk_accept;
  logic                key_we;
  logic                even_we;
  logic                odd_we;
  logic [CNT_W-1:0]    key_addr;
  logic [CNT_W-1:0]    rd_addr;
  word_t               s_even;
  word_t               s_odd;
  word_t               a_new;
  word_t               b_new;
  round_ctrl_t         rctrl;
  logic                out_load;

  assign eff_rounds = (32'(rounds) > MAX_ROUNDS) ? CNT_W'(MAX_ROUNDS) : CNT_W'(rounds);
  assign accept     = in_valid && in_ready;
  assign blk_accept = accept && (cmd == CMD_ENCRYPT || cmd == CMD_DECRYPT);
  assign key_we     = accept && (cmd == CMD_LOAD) && (32'(key_index) < KEY_DEPTH);
  assign even_we    = key_we && !key_index[0];
  assign odd_we     = key_we && key_index[0];
  assign key_addr   = CNT_W'(key_index[KEY_IDX_W-1:1]);

  rc5_ram #(.WIDTH(WORD_W), .DEPTH(PAIRS), .ADDR_W(CNT_W)) u_ram_even (
    .clk   (clk),
    .we    (even_we),
    .waddr (key_addr),
    .wdata (key_word),
    .raddr (rd_addr),
    .rdata (s_even)
  );

  rc5_ram #(.WIDTH(WORD_W), .DEPTH(PAIRS), .ADDR_W(CNT_W)) u_ram_odd (
    .clk   (clk),
    .we    (odd_we),
    .waddr (key_addr),
    .wdata (key_word),
    .raddr (rd_addr),
    .rdata (s_odd)
  );

  rc5_round u_round (
    .ctrl   (rctrl),
    .a      (a_reg),
    .b      (b_reg),
    .s_even (s_even),
    .s_odd  (s_odd),
    .a_new  (a_new),
    .b_new  (b_new)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (blk_accept) begin
          if (cmd == CMD_DECRYPT && eff_rounds != '0) begin
            state_next = ST_ROUND;
          end else begin
            state_next = ST_WHITEN;
          end
        end
      end
      ST_WHITEN: begin
        if (!dec && last != '0) begin
          state_next = ST_ROUND;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_ROUND: begin
        if (dec && cnt == CNT_W'(1)) begin
          state_next = ST_WHITEN;
        end else if (!dec && cnt == last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    rd_addr       = '0;
    rctrl.decrypt = dec;
    rctrl.whiten  = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (cmd == CMD_DECRYPT) begin
          rd_addr = eff_rounds;
        end
      end
      ST_WHITEN: begin
        rctrl.whiten = 1'b1;
        rd_addr      = CNT_W'(1);
      end
      ST_ROUND: begin
        rd_addr = dec ? cnt - CNT_W'(1) : cnt + CNT_W'(1);
      end
      ST_FINISH: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rounds    <= ROUNDS_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rounds_we) begin
        rounds <= rounds_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (blk_accept) begin
      a_reg <= half_a;
      b_reg <= half_b;
      dec   <= (cmd == CMD_DECRYPT);
      last  <= eff_rounds;
      cnt   <= eff_rounds;
    end else if (state == ST_WHITEN || state == ST_ROUND) begin
      a_reg <= a_new;
      b_reg <= b_new;
      if (state == ST_WHITEN) begin
        cnt <= CNT_W'(1);
      end else if (dec) begin
        cnt <= cnt - CNT_W'(1);
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
    if (out_load) begin
      out_a <= a_reg;
      out_b <= b_reg;
    end
  end

  `RC5_ASSERT_NEXT(a_blk_busy, clk, rst, blk_accept, state != ST_IDLE && !in_ready, "not busy")
  `RC5_ASSERT_NOW(a_round_cnt, clk, rst, state == ST_ROUND, cnt != '0 && cnt <= last, "bad count")
  `RC5_ASSERT_NOW(a_out_src, clk, rst, $rose(out_valid), $past(state) == ST_FINISH, "early result")

endmodule

`default_nettype wire
